// ===== src/region_mapped_byte_memory_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef REGION_MAPPED_BYTE_MEMORY_DEFINES_SVH
`define REGION_MAPPED_BYTE_MEMORY_DEFINES_SVH

// Check on every clock edge while out of reset.
`define RMBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define RMBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/rmbm_pkg.sv =====
package rmbm_pkg;

    localparam int REGION_BYTES = 4096;
    localparam int REGION_WORDS = (REGION_BYTES + 3) / 4;
    localparam int WADDR_W      = (REGION_WORDS > 1) ? $clog2(REGION_WORDS) : 1;
    localparam int IDX_W        = WADDR_W + 2;
    localparam int MEM_WORDS    = 3 * (2 ** WADDR_W);

    localparam logic [11:0] SEL_PROGRAM = 12'h004;
    localparam logic [11:0] SEL_DATA    = 12'h100;
    localparam logic [11:0] SEL_STACK   = 12'h7FF;

    localparam logic [1:0] BANK_PROGRAM = 2'd0;
    localparam logic [1:0] BANK_DATA    = 2'd1;
    localparam logic [1:0] BANK_STACK   = 2'd2;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2,
        SZ_BAD  = 2'd3
    } t_size;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ALIGN = 2'd2,
        ST_SIZE  = 2'd3
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [1:0]  access_size;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [3:0]       be;
        logic [3:0][7:0]  wdata;
    } t_store_req;

endpackage

// ===== src/rmbm_store.sv =====
`include "region_mapped_byte_memory_defines.svh"

module rmbm_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rmbm_pkg::t_store_req    i_req,
    output logic [3:0][7:0]         o_rdata,
    output logic                    o_clearing
);
    import rmbm_pkg::*;

    logic [3:0][7:0]  r_mem [MEM_WORDS];
    logic [3:0][7:0]  r_rd;
    logic             r_clearing;
    logic             n_clearing;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] n_clr_idx;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_idx  = r_clr_idx;
        if (r_clearing) begin
            n_clr_idx = r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(MEM_WORDS - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_idx  <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.en && i_req.we) begin
            for (int i = 0; i < 4; i++) begin
                if (i_req.be[i]) begin
                    r_mem[i_req.idx][i] <= i_req.wdata[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_rd <= r_mem[i_req.idx];
        end
    end

    assign o_rdata    = r_rd;
    assign o_clearing = r_clearing;

    `RMBM_ASSERT(a_no_access_while_clearing, r_clearing |-> !i_req.en, "access during clear")
    `RMBM_ASSERT(a_clear_ends_at_top, (r_clearing && !n_clearing) |-> (r_clr_idx == IDX_W'(MEM_WORDS - 1)), "clear ended early")
    `RMBM_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> (r_clearing && r_clr_idx == '0), "no clear after reset")

endmodule

// ===== src/region_mapped_byte_memory.sv =====
// Channel   Direction  Handshake               Payload
// in        request    i_in_valid / o_in_stall   i_in  (t_req)
// out       result     o_out_valid / i_out_stall o_out (t_rsp)
//
// One request per cycle while o_in_stall is low; its result appears in the cycle after acceptance.
// Every access touches one 32-bit word of the single-port store, so throughput is one a cycle when nothing stalls.
// After reset a clearing pass zeroes all 3 * 2**WADDR_W words (3072) of the store, request side stalled.
// A stalled result holds the store's read register; no new request is taken until it leaves.
`include "region_mapped_byte_memory_defines.svh"

module region_mapped_byte_memory (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rmbm_pkg::t_req i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rmbm_pkg::t_rsp o_out
);
    import rmbm_pkg::*;

    t_store_req      store_req;
    logic [3:0][7:0] store_rdata;
    logic            clearing;

    logic            accept;
    logic [11:0]     sel;
    logic [19:0]     off;
    logic [20:0]     off_end;
    logic [20:0]     nbytes;
    logic            hit;
    logic [1:0]      bank;
    t_size           size;

    logic            r_v1;
    logic            n_v1;
    logic            r_rd_ok;
    logic            n_rd_ok;
    logic            r_kind;
    t_status         r_status;
    t_status         n_status;
    t_size           r_size;
    logic [1:0]      r_lane;

    logic [31:0]     rdata;
    logic [15:0]     half;

    rmbm_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rdata    (store_rdata),
        .o_clearing (clearing)
    );

    assign o_in_stall = clearing || (r_v1 && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        sel  = i_in.address[31:20];
        off  = i_in.address[19:0];
        size = t_size'(i_in.access_size);
        hit  = 1'b1;
        bank = BANK_PROGRAM;
        case (sel)
            SEL_PROGRAM: bank = BANK_PROGRAM;
            SEL_DATA:    bank = BANK_DATA;
            SEL_STACK:   bank = BANK_STACK;
            default:     hit  = 1'b0;
        endcase

        case (size)
            SZ_BYTE: nbytes = 21'd1;
            SZ_HALF: nbytes = 21'd2;
            default: nbytes = 21'd4;
        endcase
        off_end = {1'b0, off} + nbytes;

        if (!hit) begin
            n_status = ST_RANGE;
        end else if (size == SZ_BAD) begin
            n_status = ST_SIZE;
        end else if ((size == SZ_HALF && off[0]) || (size == SZ_WORD && off[1:0] != 2'd0)) begin
            n_status = ST_ALIGN;
        end else if (off_end > 21'(REGION_BYTES)) begin
            n_status = ST_RANGE;
        end else begin
            n_status = ST_OK;
        end

        store_req.en  = accept;
        store_req.we  = accept && (i_in.kind == KIND_WRITE) && (n_status == ST_OK);
        store_req.idx = {bank, off[WADDR_W+1:2]};
        case (size)
            SZ_BYTE: begin
                store_req.be    = 4'b1000 >> off[1:0];
                store_req.wdata = {4{i_in.write_data[7:0]}};
            end
            SZ_HALF: begin
                store_req.be    = off[1] ? 4'b0011 : 4'b1100;
                store_req.wdata = {2{i_in.write_data[15:0]}};
            end
            default: begin
                store_req.be    = 4'b1111;
                store_req.wdata = i_in.write_data;
            end
        endcase

        n_v1    = accept ? 1'b1 : (r_v1 && i_out_stall);
        n_rd_ok = (i_in.kind == KIND_READ) && (n_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_ok  <= n_rd_ok;
            r_kind   <= i_in.kind;
            r_status <= n_status;
            r_size   <= size;
            r_lane   <= off[1:0];
        end
    end

    always_comb begin
        half  = r_lane[1] ? store_rdata[1:0] : store_rdata[3:2];
        rdata = '0;
        if (r_rd_ok) begin
            case (r_size)
                SZ_BYTE: rdata = {24'd0, store_rdata[2'(2'd3 - r_lane)]};
                SZ_HALF: rdata = {{16{half[15]}}, half};
                default: rdata = store_rdata;
            endcase
        end
        o_out.read_data = rdata;
        o_out.status    = r_status;
    end

    assign o_out_valid = r_v1;

    `RMBM_ASSERT(a_stall_while_clearing, clearing |-> o_in_stall, "request taken during clear")
    `RMBM_ASSERT(a_accept_gives_result, accept |=> o_out_valid, "accepted request lost")
    `RMBM_ASSERT(a_write_reads_zero, (r_v1 && r_kind == KIND_WRITE) |-> (o_out.read_data == 32'd0), "write returned data")
    `RMBM_ASSERT(a_error_reads_zero, (r_v1 && r_status != ST_OK) |-> (o_out.read_data == 32'd0), "error returned data")

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import rmbm_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 100;

    localparam logic [11:0] SEL_UNMAPPED_LOW  = 12'h000;
    localparam logic [11:0] SEL_UNMAPPED_NEAR = 12'h005;
    localparam logic [11:0] SEL_UNMAPPED_TOP  = 12'hFFF;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out;

    logic [7:0] shadow_bytes [3][REGION_BYTES];
    t_rsp       pending_results [$];

    int  error_count;
    int  requests_accepted;
    int  results_checked;
    int  status_seen [4];
    int  hold_off_left;
    bit  sender_gaps_on;
    bit  receiver_gaps_on;

    region_mapped_byte_memory dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

    function automatic t_rsp access_memory(input t_req req);
        t_rsp        rsp;
        logic [11:0] sel;
        int          off;
        int          nbytes;
        int          bank;
        logic [31:0] word;
        rsp.read_data = '0;
        rsp.status    = ST_OK;
        sel    = req.address[31:20];
        off    = int'(req.address[19:0]);
        nbytes = 1 << req.access_size;
        bank   = -1;
        if (sel == SEL_PROGRAM) begin
            bank = BANK_PROGRAM;
        end else if (sel == SEL_DATA) begin
            bank = BANK_DATA;
        end else if (sel == SEL_STACK) begin
            bank = BANK_STACK;
        end
        if (bank < 0) begin
            rsp.status = ST_RANGE;
        end else if (req.access_size == SZ_BAD) begin
            rsp.status = ST_SIZE;
        end else if ((off % nbytes) != 0) begin
            rsp.status = ST_ALIGN;
        end else if (off + nbytes > REGION_BYTES) begin
            rsp.status = ST_RANGE;
        end else if (req.kind == KIND_WRITE) begin
            for (int i = 0; i < nbytes; i++)
                shadow_bytes[bank][off + i] = req.write_data[8 * (nbytes - 1 - i) +: 8];
        end else begin
            word = '0;
            for (int i = 0; i < nbytes; i++)
                word = {word[23:0], shadow_bytes[bank][off + i]};
            if (req.access_size == SZ_HALF && word[15])
                word[31:16] = '1;
            rsp.read_data = word;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin : check_and_predict
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", o_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, o_out.read_data);
                    error_count++;
                end
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    error_count++;
                end
                results_checked++;
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            want = access_memory(i_in);
            pending_results.push_back(want);
            requests_accepted++;
            status_seen[want.status]++;
        end
    end

    initial begin : result_stall
        int burst_left;
        burst_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (receiver_gaps_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(1, 5) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_req make_req(input logic kind, input logic [11:0] sel,
                                      input logic [19:0] off, input logic [31:0] data,
                                      input logic [1:0] size);
        t_req req;
        req.kind        = kind;
        req.address     = {sel, off};
        req.write_data  = data;
        req.access_size = size;
        return req;
    endfunction

    task automatic send_request(input t_req req);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic t_req random_request();
        logic [11:0] sel;
        logic [19:0] off;
        logic [1:0]  size;
        int          pick;
        pick = $urandom_range(0, 19);
        size = 2'($urandom_range(SZ_BYTE, SZ_WORD));
        case ($urandom_range(0, 2))
            0: sel = SEL_PROGRAM;
            1: sel = SEL_DATA;
            default: sel = SEL_STACK;
        endcase
        if (pick < 12) begin
            off = 20'($urandom_range(0, 31));
        end else if (pick < 15) begin
            off = 20'($urandom_range(0, REGION_BYTES - 1));
        end else if (pick < 17) begin
            off = 20'(REGION_BYTES - $urandom_range(1, 8));
        end else begin
            off = 20'($urandom);
        end
        if (pick < 17)
            off = off & ~20'((1 << size) - 1);
        if (pick == 18)
            size = SZ_BAD;
        if (pick == 19) begin
            sel  = 12'($urandom >> 20);
            size = 2'($urandom);
        end
        return make_req(1'($urandom), sel, off, $urandom, size);
    endfunction

    task automatic test_directed();
        send_request(make_req(KIND_READ,  SEL_PROGRAM, 20'h0, 32'h0, SZ_WORD));
        send_request(make_req(KIND_WRITE, SEL_PROGRAM, 20'h0, 32'h80FF_7F01, SZ_WORD));
        send_request(make_req(KIND_READ,  SEL_PROGRAM, 20'h0, 32'h0, SZ_WORD));
        send_request(make_req(KIND_READ,  SEL_PROGRAM, 20'h0, 32'h0, SZ_HALF));
        send_request(make_req(KIND_READ,  SEL_PROGRAM, 20'h2, 32'h0, SZ_HALF));
        send_request(make_req(KIND_READ,  SEL_PROGRAM, 20'h1, 32'h0, SZ_BYTE));
        send_request(make_req(KIND_WRITE, SEL_DATA, 20'hFFF, 32'hFFFF_FFA5, SZ_BYTE));
        send_request(make_req(KIND_READ,  SEL_DATA, 20'hFFF, 32'hFFFF_FFFF, SZ_BYTE));
        send_request(make_req(KIND_WRITE, SEL_STACK, 20'hFFE, 32'h1234_ABCD, SZ_HALF));
        send_request(make_req(KIND_READ,  SEL_STACK, 20'hFFE, 32'h0, SZ_HALF));
        send_request(make_req(KIND_WRITE, SEL_STACK, 20'hFFC, 32'hFFFF_FFFF, SZ_WORD));
        send_request(make_req(KIND_READ,  SEL_STACK, 20'hFFC, 32'h0, SZ_WORD));
        send_request(make_req(KIND_READ,  SEL_STACK, 20'hFFE, 32'h0, SZ_HALF));
        send_request(make_req(KIND_READ,  SEL_UNMAPPED_LOW, 20'h0, 32'h0, SZ_WORD));
        send_request(make_req(KIND_WRITE, SEL_UNMAPPED_TOP, 20'hFFFFF, 32'hFFFF_FFFF,
                              SZ_BYTE));
        send_request(make_req(KIND_READ,  SEL_UNMAPPED_NEAR, 20'h0, 32'h0, SZ_BYTE));
        send_request(make_req(KIND_READ,  SEL_DATA, 20'h0, 32'h0, SZ_BAD));
        send_request(make_req(KIND_WRITE, SEL_PROGRAM, 20'h0, 32'h0, SZ_BAD));
        send_request(make_req(KIND_READ,  SEL_PROGRAM, 20'h0, 32'h0, SZ_WORD));
        send_request(make_req(KIND_WRITE, SEL_DATA, 20'h1, 32'hDEAD_BEEF, SZ_HALF));
        send_request(make_req(KIND_WRITE, SEL_DATA, 20'h2, 32'hDEAD_BEEF, SZ_WORD));
        send_request(make_req(KIND_READ,  SEL_DATA, 20'h3, 32'h0, SZ_WORD));
        send_request(make_req(KIND_READ,  SEL_DATA, 20'h1000, 32'h0, SZ_BYTE));
        send_request(make_req(KIND_WRITE, SEL_DATA, 20'hFFFFC, 32'h5555_AAAA, SZ_WORD));
        send_request(make_req(KIND_READ,  SEL_DATA, 20'hFFF, 32'h0, SZ_BYTE));
    endtask

    // hold the result side while requests keep coming, so the input stalls
    task automatic test_pressure();
        hold_off_left = HOLD_CYCLES;
        repeat (40) send_request(random_request());
    endtask

    task automatic test_random(input int count);
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        repeat (count) send_request(random_request());
    endtask

    task automatic test_back_to_back(input int count);
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        repeat (count) send_request(random_request());
    endtask

    initial begin
        foreach (shadow_bytes[b, a]) shadow_bytes[b][a] = '0;
        error_count       = 0;
        requests_accepted = 0;
        results_checked   = 0;
        hold_off_left     = 0;
        sender_gaps_on    = 1'b1;
        receiver_gaps_on  = 1'b1;
        foreach (status_seen[s]) status_seen[s] = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pressure();
        test_random(440);
        test_back_to_back(40);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("results missing: expected 0 outstanding, got %0d",
                   pending_results.size());
            error_count++;
        end

        $display("tb: %0d requests across program, data and stack regions, %0d results checked",
                 requests_accepted, results_checked);
        $display("tb: ok %0d, out of range %0d, misaligned %0d, bad size %0d",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_ALIGN],
                 status_seen[ST_SIZE]);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rmbm_pkg.sv
src/rmbm_store.sv
src/region_mapped_byte_memory.sv
tb/sv/testbench.sv
